/* design/cbpe_pkg.sv */
// Shared constants and width helpers for the cubic B-spline point evaluator.
`default_nettype none

package cbpe_pkg;

    // Default sizes of the control point coordinates and the frame index
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAME_BITS_DEF = 8;

    // Width of one output coordinate
    localparam int OUT_BITS = 32;

    // Control point register map
    localparam int NUM_REGS      = 8;
    localparam int REG_IDX_BITS  = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_P0_X = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_P0_Y = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_P1_X = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_P1_Y = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_P2_X = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_P2_Y = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_P3_X = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_P3_Y = 3'd7;

    // Divider split: 48000 = 2^7 * 375, quotient built one byte per stage
    localparam int DIV_SHIFT  = 7;
    localparam int DIGIT_BITS = 8;

    // Signed width that holds the weighted sum over the 48000 denominator
    function automatic int sum_width(input int coord_bits, input int frame_bits);
        return coord_bits + 3 * frame_bits + 5;
    endfunction

    // Number of quotient bytes produced by the digit stages
    function automatic int digit_count(input int coord_bits, input int frame_bits);
        return (sum_width(coord_bits, frame_bits) - DIV_SHIFT + DIGIT_BITS - 1) / DIGIT_BITS;
    endfunction

    // Cycles from input transfer to result in the output register
    function automatic int latency(input int coord_bits, input int frame_bits);
        return digit_count(coord_bits, frame_bits) + 6;
    endfunction

endpackage

`default_nettype wire

/* design/cbpe_lane.sv */
// One coordinate lane: polynomial evaluation by Horner steps and truncating divide by 48000.
`default_nettype none

module cbpe_lane #(
    parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF,
    parameter int FRAME_BITS = cbpe_pkg::FRAME_BITS_DEF
) (
    input  wire                             clk,
    input  wire                             en,
    input  wire        [FRAME_BITS-1:0]     frame,
    input  wire signed [COORD_BITS-1:0]     pt0,
    input  wire signed [COORD_BITS-1:0]     pt1,
    input  wire signed [COORD_BITS-1:0]     pt2,
    input  wire signed [COORD_BITS-1:0]     pt3,
    output logic       [cbpe_pkg::OUT_BITS-1:0] result
);

    localparam int SW   = cbpe_pkg::sum_width(COORD_BITS, FRAME_BITS);
    localparam int ND   = cbpe_pkg::digit_count(COORD_BITS, FRAME_BITS);
    localparam int DB   = cbpe_pkg::DIGIT_BITS;
    localparam int DW   = ND * DB;
    localparam int FW   = FRAME_BITS + 1;
    localparam int PW   = SW + FW;
    localparam int QX   = (DW > cbpe_pkg::OUT_BITS) ? DW : cbpe_pkg::OUT_BITS;
    localparam int QXW  = QX + 1;

    // Per-digit division by 375 through a reciprocal multiply
    localparam int REM_BITS    = 9;
    localparam int V_BITS      = REM_BITS + DB;
    localparam int RECIP_SHIFT = 26;
    localparam int RP_BITS     = 35;
    localparam logic [RP_BITS-1:0] RECIP      = 35'd178957;
    localparam logic [V_BITS-1:0]  DIGIT_DIV  = 17'd375;

    // Basis coefficient scale factors over the 48000 denominator
    localparam logic signed [SW-1:0] K2 = SW'(60);
    localparam logic signed [SW-1:0] K1 = SW'(1200);
    localparam logic signed [SW-1:0] K0 = SW'(8000);

    logic signed [SW-1:0] p0w, p1w, p2w, p3w;
    logic signed [SW-1:0] c3_next, c2_next, c1_next, c0_next;

    logic [FRAME_BITS-1:0] f_a_reg, f_b_reg, f_c_reg;
    logic signed [SW-1:0]  c3_a_reg, c2_a_reg, c1_a_reg, c0_a_reg;
    logic signed [SW-1:0]  c1_b_reg, c0_b_reg, c0_c_reg;
    logic signed [SW-1:0]  h1_b_reg, h1_next;
    logic signed [SW-1:0]  h2_c_reg, h2_next;
    logic signed [SW-1:0]  s_d_reg, s_next;
    logic signed [FW-1:0]  fs_a, fs_b, fs_c;
    logic signed [PW-1:0]  prod_b, prod_c, prod_d;
    logic [SW-1:0]         abs_val;

    logic [DW-1:0]       dvd_reg [ND+1];
    logic [DW-1:0]       quo_reg [ND+1];
    logic [REM_BITS-1:0] rem_reg [ND+1];
    logic                neg_reg [ND+1];

    logic [QXW-1:0] qext;
    logic [QXW-1:0] res_next;
    logic [cbpe_pkg::OUT_BITS-1:0] result_reg;

    // Fold the four control points into polynomial coefficients in f
    always_comb
    begin
        p0w     = SW'(pt0);
        p1w     = SW'(pt1);
        p2w     = SW'(pt2);
        p3w     = SW'(pt3);
        c3_next = (p3w - p0w) + (p1w - p2w) * SW'(3);
        c2_next = (p0w - (p1w <<< 1) + p2w) * K2;
        c1_next = (p2w - p0w) * K1;
        c0_next = (p0w + (p1w <<< 2) + p2w) * K0;
    end

    // Horner steps, one multiply per stage
    always_comb
    begin
        fs_a    = $signed({1'b0, f_a_reg});
        fs_b    = $signed({1'b0, f_b_reg});
        fs_c    = $signed({1'b0, f_c_reg});
        prod_b  = c3_a_reg * fs_a;
        h1_next = prod_b[SW-1:0] + c2_a_reg;
        prod_c  = h1_b_reg * fs_b;
        h2_next = prod_c[SW-1:0] + c1_b_reg;
        prod_d  = h2_c_reg * fs_c;
        s_next  = prod_d[SW-1:0] + c0_c_reg;
        abs_val = s_d_reg[SW-1] ? SW'(-s_d_reg) : SW'(s_d_reg);
    end

    // Advance coefficient and Horner stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_a_reg  <= frame;
            c3_a_reg <= c3_next;
            c2_a_reg <= c2_next;
            c1_a_reg <= c1_next;
            c0_a_reg <= c0_next;

            f_b_reg  <= f_a_reg;
            h1_b_reg <= h1_next;
            c1_b_reg <= c1_a_reg;
            c0_b_reg <= c0_a_reg;

            f_c_reg  <= f_b_reg;
            h2_c_reg <= h2_next;
            c0_c_reg <= c0_b_reg;

            s_d_reg  <= s_next;

            // Split sign and magnitude, drop the power-of-two part of the divisor
            neg_reg[0] <= s_d_reg[SW-1];
            dvd_reg[0] <= DW'(abs_val[SW-1:cbpe_pkg::DIV_SHIFT]);
            quo_reg[0] <= '0;
            rem_reg[0] <= '0;
        end
    end

    // Digit stages: divide by 375 one byte per stage, most significant first
    for (genvar k = 0; k < ND; k++)
    begin : g_digit
        logic [V_BITS-1:0]  v;
        logic [RP_BITS-1:0] rp;
        logic [DB-1:0]      q;
        logic [V_BITS-1:0]  r;

        always_comb
        begin
            v  = {rem_reg[k], dvd_reg[k][DW-1 -: DB]};
            rp = RP_BITS'(v) * RECIP;
            q  = rp[RECIP_SHIFT+DB-1:RECIP_SHIFT];
            r  = v - V_BITS'(q) * DIGIT_DIV;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[k+1] <= neg_reg[k];
                dvd_reg[k+1] <= dvd_reg[k] << DB;
                quo_reg[k+1] <= {quo_reg[k][DW-DB-1:0], q};
                rem_reg[k+1] <= r[REM_BITS-1:0];
            end
        end
    end

    // Restore the sign and keep the low 32 bits
    always_comb
    begin
        qext     = QXW'(quo_reg[ND]);
        res_next = neg_reg[ND] ? (~qext + QXW'(1)) : qext;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= res_next[cbpe_pkg::OUT_BITS-1:0];
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* design/cubic_bspline_point_eval_unit.sv */
// Top level of the uniform cubic B-spline point evaluator.
//
// Usage:
//   Load the four control points through the write port (cfg_we, cfg_addr,
//   cfg_data); index order is p0.x, p0.y, p1.x, p1.y, p2.x, p2.y, p3.x, p3.y.
//   Write them only while no frame is in flight.
//   Stream frame numbers in on the s_ side; each transfer yields one point
//   (x, y) on the m_ side, the curve at t = frame / 20, truncated toward zero.
//   From input transfer to m_tvalid a frame passes one coefficient stage,
//   three Horner multiply stages, a sign/magnitude stage, one stage per
//   quotient byte of the divide by 375, and the output register.
//   Throughput is one frame per cycle unless the receiver stalls;
//   both lanes run in parallel.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and s_tready drops; nothing is dropped or repeated.
//   Reset clears the control points to zero and empties the pipeline.
`default_nettype none

module cubic_bspline_point_eval_unit #(
    parameter int COORD_BITS = cbpe_pkg::COORD_BITS_DEF,
    parameter int FRAME_BITS = cbpe_pkg::FRAME_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // Control point write port
    input  wire                                  cfg_we,
    input  wire  [cbpe_pkg::REG_IDX_BITS-1:0]    cfg_addr,
    input  wire  [COORD_BITS-1:0]                cfg_data,
    // Frame input stream
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    input  wire  [((FRAME_BITS + 7) / 8) * 8 - 1:0] s_tdata, // frame_number
    // Point output stream
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    output logic [2 * cbpe_pkg::OUT_BITS - 1:0]  m_tdata  // pos_x, pos_y
);

    localparam int LAT = cbpe_pkg::latency(COORD_BITS, FRAME_BITS);

    logic signed [COORD_BITS-1:0] point_reg [cbpe_pkg::NUM_REGS];
    logic [LAT-1:0]               vld_reg;
    logic [LAT-1:0]               vld_next;
    logic                         adv;
    logic [cbpe_pkg::OUT_BITS-1:0] pos_x;
    logic [cbpe_pkg::OUT_BITS-1:0] pos_y;

    // Hold control points
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < cbpe_pkg::NUM_REGS; i++)
            begin
                point_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            point_reg[cfg_addr] <= cfg_data;
        end
    end

    // Advance the whole pipeline unless a result waits on a stalled receiver
    always_comb
    begin
        adv      = !m_tvalid || m_tready;
        vld_next = {vld_reg[LAT-2:0], s_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = adv;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {pos_y, pos_x};

    // x lane
    cbpe_lane #(
        .COORD_BITS (COORD_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_lane_x (
        .clk    (clk),
        .en     (adv),
        .frame  (s_tdata[FRAME_BITS-1:0]),
        .pt0    (point_reg[cbpe_pkg::REG_P0_X]),
        .pt1    (point_reg[cbpe_pkg::REG_P1_X]),
        .pt2    (point_reg[cbpe_pkg::REG_P2_X]),
        .pt3    (point_reg[cbpe_pkg::REG_P3_X]),
        .result (pos_x)
    );

    // y lane
    cbpe_lane #(
        .COORD_BITS (COORD_BITS),
        .FRAME_BITS (FRAME_BITS)
    ) u_lane_y (
        .clk    (clk),
        .en     (adv),
        .frame  (s_tdata[FRAME_BITS-1:0]),
        .pt0    (point_reg[cbpe_pkg::REG_P0_Y]),
        .pt1    (point_reg[cbpe_pkg::REG_P1_Y]),
        .pt2    (point_reg[cbpe_pkg::REG_P2_Y]),
        .pt3    (point_reg[cbpe_pkg::REG_P3_Y]),
        .result (pos_y)
    );

    // An accepted frame occupies the first stage on the next cycle
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted frame did not enter the pipeline");

    // A stalled result freezes every stage
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during an output stall");

    // A taken result with an empty stage behind it leaves no output
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !vld_reg[LAT-2]) |=> !m_tvalid)
        else $error("result repeated after transfer");

    // No frame is taken while a result is blocked
    a_no_take_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");

endmodule

`default_nettype wire
